/* rtl/tt800rg_pkg.sv */
// Shared constants and helper functions for the TT800 generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tt800rg_pkg;

	localparam int WORDS      = 25;
	localparam int MID        = 18;
	localparam int SHIFT_OFF  = WORDS - MID;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = $clog2(WORDS);

	localparam logic [WORD_W-1:0] TWIST_MASK  = 32'h8EBF_D028;
	localparam logic [WORD_W-1:0] LCG_MUL     = 32'h41C6_4E6D;
	localparam logic [WORD_W-1:0] LCG_ADD     = 32'h0000_3039;
	localparam logic [WORD_W-1:0] TEMPER_B    = 32'h2B5B_2500;
	localparam logic [WORD_W-1:0] TEMPER_C    = 32'hDB8B_0000;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'h0000_0001;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic start;
		logic step;
	} lcg_ctrl_t;

	function automatic word_t salt_word(input logic [IDX_W-1:0] idx);
		word_t w;
		unique case (idx)
			5'd0:    w = 32'h95F2_4DAB;
			5'd1:    w = 32'h0B68_5125;
			5'd2:    w = 32'hE76C_CAE7;
			5'd3:    w = 32'hAF3E_C239;
			5'd4:    w = 32'h715F_AD23;
			5'd5:    w = 32'h24A5_90AD;
			5'd6:    w = 32'h69E4_B5EF;
			5'd7:    w = 32'hBF45_6141;
			5'd8:    w = 32'h96BC_1B7B;
			5'd9:    w = 32'hA7BD_F825;
			5'd10:   w = 32'hC1DE_75B7;
			5'd11:   w = 32'h8858_A9C9;
			5'd12:   w = 32'h3DA8_7693;
			5'd13:   w = 32'hB657_F9DD;
			5'd14:   w = 32'hFFDC_8A9F;
			5'd15:   w = 32'h8121_DA71;
			5'd16:   w = 32'h8B82_3ECB;
			5'd17:   w = 32'h885D_05F5;
			5'd18:   w = 32'h4E20_CD47;
			5'd19:   w = 32'h5A9A_D5D9;
			5'd20:   w = 32'h512C_0C03;
			5'd21:   w = 32'hEA85_7CCD;
			5'd22:   w = 32'h4CC1_D30F;
			5'd23:   w = 32'h8891_A9A1;
			5'd24:   w = 32'hA6B7_AADB;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic word_t twist_word(input word_t partner, input word_t w);
		return partner ^ (w >> 1) ^ (w[0] ? TWIST_MASK : '0);
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 16);
		return y;
	endfunction

endpackage

/* rtl/tt800rg_cell.sv */
// One state word of the generator ring; shifts in its neighbor's word on enable.
// Depends on tt800rg_pkg.
`timescale 1ns / 1ps

module tt800rg_cell
	import tt800rg_pkg::*;
(
	input  logic  clk,
	input  logic  shift,
	input  word_t d,
	output word_t q
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

/* rtl/tt800rg_lcg.sv */
// Seeding source: 32-bit LCG stepped once per cycle while ctrl.step is set, salted from the constant table.
// Depends on tt800rg_pkg.
`timescale 1ns / 1ps

module tt800rg_lcg
	import tt800rg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lcg_ctrl_t ctrl,
	input  word_t     seed,
	output word_t     word
);

	word_t            x_q;
	logic [IDX_W-1:0] idx_q;
	word_t            x_next;
	word_t            salt;
	word_t            mixed;

	assign x_next = x_q * LCG_MUL + LCG_ADD;
	assign salt   = salt_word(idx_q);
	assign mixed  = x_next ^ salt;
	// an all-zero word would stall the twist, so fall back to the salt
	assign word   = (mixed == '0) ? salt : mixed;

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= seed;
		end else if (ctrl.step) begin
			x_q <= x_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.start) begin
			idx_q <= '0;
		end else if (ctrl.step) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

/* rtl/tt800rg_random_generator_top.sv */
// TT800 generator: the user should know that a draw transaction returns one tempered
// 32-bit word and is taken in a single cycle, back to back while the result register drains,
// because the 25 state words form a ring of cells that shifts once per draw with the twist
// feedback computed from the head word and the word seven cells down. A reseed transaction
// returns nothing and keeps the block busy while it loads 25 LCG words (one 32x32 multiply
// per cycle) and then applies 25 twist shifts. A draw arriving before any reseed first seeds
// with 1, so its word appears only after that seeding is done.
// Depends on tt800rg_pkg, tt800rg_cell and tt800rg_lcg.
`timescale 1ns / 1ps

module tt800_random_generator_top
	import tt800rg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [31:0] seed,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] value
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_TWIST = 2'd2;
	localparam logic [1:0] ST_DRAW  = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             seeded_q;
	logic             pending_q;
	logic             value_valid_q;
	word_t            value_q;

	word_t            words [WORDS];
	word_t            lcg_word;
	word_t            tail;
	lcg_ctrl_t        lcg_ctrl;
	logic             item_fire;
	logic             draw_fire;
	logic             shift;
	logic             slot_free;
	logic             cnt_last;

	assign slot_free  = !value_valid_q || result_ready;
	assign item_ready = (state_q == ST_IDLE) && slot_free;
	assign item_fire  = item_valid && item_ready;
	assign draw_fire  = (item_fire && !action && seeded_q) || (state_q == ST_DRAW);
	assign shift      = (state_q == ST_LOAD) || (state_q == ST_TWIST) || draw_fire;
	assign cnt_last   = (cnt_q == IDX_W'(WORDS - 1));

	assign lcg_ctrl.start = item_fire && (action || !seeded_q);
	assign lcg_ctrl.step  = (state_q == ST_LOAD);

	// draws keep twisting in the same ring, so every 25 draws the ring holds the next state
	assign tail = (state_q == ST_LOAD) ? lcg_word : twist_word(words[SHIFT_OFF], words[0]);

	tt800rg_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lcg_ctrl),
		.seed   (action ? seed : DEFAULT_SEED),
		.word   (lcg_word)
	);

	for (genvar i = 0; i < WORDS; i++) begin : g_cell
		if (i == WORDS - 1) begin : g_tail
			tt800rg_cell u_cell (.clk(clk), .shift(shift), .d(tail), .q(words[i]));
		end else begin : g_body
			tt800rg_cell u_cell (.clk(clk), .shift(shift), .d(words[i+1]), .q(words[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			seeded_q  <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (lcg_ctrl.start) begin
						state_q   <= ST_LOAD;
						cnt_q     <= '0;
						pending_q <= !action;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
					if (cnt_last) begin
						state_q <= ST_TWIST;
					end
				end
				ST_TWIST: begin
					cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
					if (cnt_last) begin
						seeded_q  <= 1'b1;
						pending_q <= 1'b0;
						state_q   <= pending_q ? ST_DRAW : ST_IDLE;
					end
				end
				ST_DRAW: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid_q <= 1'b0;
		end else if (draw_fire) begin
			value_valid_q <= 1'b1;
		end else if (result_ready) begin
			value_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_fire) begin
			value_q <= temper(words[0]);
		end
	end

	assign result_valid = value_valid_q;
	assign value        = value_q;

	// a draw never overwrites a result still waiting to be taken
	a_draw_slot: assert property (@(posedge clk) disable iff (!arst_n)
		draw_fire |-> slot_free)
		else $error("draw overwrote pending result");

	// the deferred draw only runs on a freshly seeded ring
	a_draw_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> seeded_q)
		else $error("deferred draw before seeding");

	// a reseed transaction accepted with no result pending produces no result in the next cycle
	a_reseed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && action && !value_valid_q) |=> !value_valid_q)
		else $error("reseed produced a result");

	// a pending draw only exists while seeding is in progress
	a_pending_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> ((state_q == ST_LOAD) || (state_q == ST_TWIST)))
		else $error("stale pending draw");

endmodule

/* tb/tb_tt800_random_generator_top.sv */
// Self-checking testbench for tt800_random_generator_top: reseed and draw transactions,
// with every drawn word checked against a predictor of the TT800 generator held here.
// Depends only on the RTL of the block.
`timescale 1ns / 1ps

module tb_tt800_random_generator_top;

	localparam int N_WORDS = 25;
	localparam int N_MID   = 18;
	localparam int N_OFF   = 7;

	localparam logic [31:0] TWIST_XOR   = 32'h8EBF_D028;
	localparam logic [31:0] LCG_MULT    = 32'h41C6_4E6D;
	localparam logic [31:0] LCG_INC     = 32'h0000_3039;
	localparam logic [31:0] TEMPER_MASK_B = 32'h2B5B_2500;
	localparam logic [31:0] TEMPER_MASK_C = 32'hDB8B_0000;
	localparam logic [31:0] POWER_ON_SEED = 32'h0000_0001;

	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_RESEED = 1'b1;

	localparam int RANDOM_ITEMS = 430;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [31:0] SALT [N_WORDS] = '{
		32'h95F24DAB, 32'h0B685125, 32'hE76CCAE7, 32'hAF3EC239, 32'h715FAD23,
		32'h24A590AD, 32'h69E4B5EF, 32'hBF456141, 32'h96BC1B7B, 32'hA7BDF825,
		32'hC1DE75B7, 32'h8858A9C9, 32'h3DA87693, 32'hB657F9DD, 32'hFFDC8A9F,
		32'h8121DA71, 32'h8B823ECB, 32'h885D05F5, 32'h4E20CD47, 32'h5A9AD5D9,
		32'h512C0C03, 32'hEA857CCD, 32'h4CC1D30F, 32'h8891A9A1, 32'hA6B7AADB
	};

	// zero_word set: the seed field holds a word index, and the seed sent is the one
	// that makes that salted word come out zero
	typedef struct packed {
		logic        act;
		logic        zero_word;
		logic [31:0] seed;
	} stim_t;

	localparam int N_DIRECTED = 21;
	localparam stim_t DIRECTED [N_DIRECTED] = '{
		'{ACT_DRAW,   1'b0, 32'h0000_0000},	// draw before any reseed
		'{ACT_DRAW,   1'b0, 32'hFFFF_FFFF},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b0, 32'h0000_0001},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b0, 32'h0000_0000},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b0, 32'hFFFF_FFFF},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b1, 32'd0},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b1, 32'd24},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_RESEED, 1'b1, 32'd12},
		'{ACT_RESEED, 1'b0, 32'h8000_0000},	// back-to-back reseeds
		'{ACT_DRAW,   1'b0, 32'hFFFF_FFFF},
		'{ACT_RESEED, 1'b0, 32'h5555_5555},
		'{ACT_DRAW,   1'b0, 32'hAAAA_AAAA},
		'{ACT_DRAW,   1'b0, 32'h0000_0000},
		'{ACT_DRAW,   1'b0, 32'h0000_0000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        action = ACT_DRAW;
	logic [31:0] seed = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] value;

	// generator state as the predictor sees it
	logic [31:0] gen_words [N_WORDS];
	int          gen_pos = 0;
	logic        gen_seeded = 1'b0;

	logic [31:0] pending_words [$];
	int          mismatches = 0;
	int          cycles = 0;

	logic [15:0] ready_pat = 16'hFFFF;
	int          pat_age = 0;

	tt800_random_generator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.seed         (seed),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("MISMATCH %s: expected %08h, got %08h at cycle %0d", what, want, got, cycles);
		mismatches++;
	endtask

	function automatic void twist_words();
		logic [31:0] partner;
		logic [31:0] w;
		for (int i = 0; i < N_WORDS; i++) begin
			partner = (i < N_MID) ? gen_words[i + N_OFF] : gen_words[i - N_MID];
			w = gen_words[i];
			gen_words[i] = partner ^ (w >> 1) ^ (w[0] ? TWIST_XOR : 32'h0);
		end
	endfunction

	function automatic void reseed_words(input logic [31:0] s);
		logic [31:0] x;
		logic [31:0] w;
		x = s;
		for (int i = 0; i < N_WORDS; i++) begin
			x = x * LCG_MULT + LCG_INC;
			w = x ^ SALT[i];
			gen_words[i] = (w == 32'h0) ? SALT[i] : w;
		end
		twist_words();
		gen_pos = 0;
		gen_seeded = 1'b1;
	endfunction

	function automatic logic [31:0] tempered(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ ((y << 7) & TEMPER_MASK_B);
		y = y ^ ((y << 15) & TEMPER_MASK_C);
		y = y ^ (y >> 16);
		return y;
	endfunction

	function automatic logic [31:0] next_draw();
		logic [31:0] y;
		if (!gen_seeded)
			reseed_words(POWER_ON_SEED);
		if (gen_pos >= N_WORDS) begin
			twist_words();
			gen_pos = 0;
		end
		y = tempered(gen_words[gen_pos]);
		gen_pos++;
		return y;
	endfunction

	// seed whose LCG sequence equals the salt at word k, so that word salts to zero
	function automatic logic [31:0] zeroing_seed(input int k);
		logic [31:0] inv;
		logic [31:0] x;
		inv = LCG_MULT;
		for (int j = 0; j < 5; j++)
			inv = inv * (32'd2 - LCG_MULT * inv);
		x = SALT[k];
		for (int j = 0; j <= k; j++)
			x = (x - LCG_INC) * inv;
		return x;
	endfunction

	// prediction on accepted input, checking on accepted output, in one process
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				if (action == ACT_RESEED)
					reseed_words(seed);
				else
					pending_words.push_back(next_draw());
			end
			if (result_valid && result_ready) begin
				if (pending_words.size() == 0) begin
					report_mismatch("unexpected value", 32'h0, value);
				end else begin
					want = pending_words.pop_front();
					if (value !== want)
						report_mismatch("value", want, value);
				end
			end
		end
	end

	// receiver: rotating stall pattern, replaced now and then, sometimes never stalling
	always @(negedge clk) begin
		if (pat_age == 0) begin
			pat_age = $urandom_range(50, 300);
			if ($urandom_range(0, 2) == 0)
				ready_pat = 16'hFFFF;
			else
				ready_pat = 16'($urandom()) | 16'h0101;
		end
		pat_age--;
		result_ready <= ready_pat[0];
		ready_pat = {ready_pat[0], ready_pat[15:1]};
	end

	initial begin
		stim_t item;
		int    burst_left;
		int    gap;
		bit    no_idle;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int n = 0; n < N_DIRECTED + RANDOM_ITEMS; n++) begin
			if (n < N_DIRECTED) begin
				item = DIRECTED[n];
			end else begin
				item.act = ($urandom_range(0, 24) == 0) ? ACT_RESEED : ACT_DRAW;
				// long run of plain draws first, so the state wraps several times
				if (n < N_DIRECTED + 60)
					item.act = ACT_DRAW;
				item.zero_word = 1'b0;
				case ($urandom_range(0, 7))
					0: item.seed = 32'h0000_0000;
					1: item.seed = 32'hFFFF_FFFF;
					2, 3: begin
						item.zero_word = (item.act == ACT_RESEED);
						item.seed = $urandom_range(0, N_WORDS - 1);
					end
					default: item.seed = $urandom();
				endcase
			end
			if (item.zero_word)
				item.seed = zeroing_seed(int'(item.seed));

			no_idle = (n >= N_DIRECTED && n < N_DIRECTED + 60) || (n >= 300 && n < 340);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if (no_idle)
					gap = 0;
				else if ($urandom_range(0, 3) == 0)
					gap = $urandom_range(10, 60);
				else
					gap = $urandom_range(0, 4);
				repeat (gap) begin
					item_valid <= 1'b0;
					@(negedge clk);
				end
			end
			item_valid <= 1'b1;
			action <= item.act;
			seed <= item.seed;
			@(posedge clk);
			while (!item_ready)
				@(posedge clk);
			burst_left--;
			@(negedge clk);
		end
		item_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/tt800rg_pkg.sv
rtl/tt800rg_cell.sv
rtl/tt800rg_lcg.sv
rtl/tt800rg_random_generator_top.sv
tb/tb_tt800_random_generator_top.sv
